// File: src/cfw_pkg.sv
// cfw_pkg: shared types, register codes and fixed-point helpers for the
// cepstrum frequency warp block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cfw_pkg;

    localparam int unsigned MAX_ORDER_DEF = 63;

    // register indexes, byte address 4*index
    localparam logic [1:0] REG_WARP_A       = 2'd0;
    localparam logic [1:0] REG_WARP_B       = 2'd1;
    localparam logic [1:0] REG_OUTPUT_ORDER = 2'd2;

    localparam logic signed [15:0] WARP_A_RST       = 16'sd0;
    localparam logic [15:0]        WARP_B_RST       = 16'd32768;
    localparam logic [5:0]         OUTPUT_ORDER_RST = 6'd24;

    localparam logic signed [34:0] SAT32_MAX = 35'sd2147483647;
    localparam logic signed [34:0] SAT32_MIN = -35'sd2147483648;
    localparam logic signed [31:0] SAT24_MAX = 32'sd8388607;
    localparam logic signed [31:0] SAT24_MIN = -32'sd8388608;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FLUSH,
        ST_DRAIN
    } state_t;

    // token handed from one cell to the next: old and new value of the cell
    typedef struct packed {
        logic               valid;
        logic signed [31:0] old_val;
        logic signed [31:0] new_val;
    } tok_t;

    // chain-wide drain control
    typedef struct packed {
        logic shift;
        logic clear;
    } ctl_t;

    // Q.31 product back to Q.16, round half up
    function automatic logic signed [33:0] rnd15(input logic signed [48:0] p);
        logic signed [48:0] q;
        begin
            q = p + 49'sd16384;
            return q[48:15];
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        begin
            if (v > SAT32_MAX)
            begin
                return 32'sh7FFF_FFFF;
            end
            else if (v < SAT32_MIN)
            begin
                return 32'sh8000_0000;
            end
            return v[31:0];
        end
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
        begin
            if (v > SAT24_MAX)
            begin
                return 24'sh7F_FFFF;
            end
            else if (v < SAT24_MIN)
            begin
                return 24'sh80_0000;
            end
            return v[23:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: src/cepstrum_frequency_warp.sv
// cepstrum_frequency_warp: all-pass frequency warping of cepstral frames
// top level with register port, cell chain and drain control; uses cfw_pkg, cfw_cell
`timescale 1ns / 1ps
`default_nettype none

//  channel   handshake                     payload
//  config    psel/penable/pwrite, pready   paddr, pwdata, prdata
//  input     in_valid / in_ready           coefficient, frame_last
//  output    out_valid / out_ready         warped_value, warped_index, frame_done
//
// one coefficient item per cycle while a frame streams in; the update runs
// as a wavefront down the chain, each cell taking an item from its left neighbour's token
// after the frame's last item the input stays closed while the wavefront
// crosses the active cells and while order+1 results shift out of cell 0
// at one per cycle as out_ready allows, and the chain is cleared
// reset clears cells and control, loads config reset values at once; no clearing pass
// a stalled output only stalls the drain; the output register frees the input side

module cepstrum_frequency_warp #(
    parameter int unsigned MAX_ORDER = cfw_pkg::MAX_ORDER_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // coefficient items in
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [23:0] coefficient,
    input  wire logic               frame_last,
    // warped items out
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [23:0]      warped_value,
    output logic [5:0]              warped_index,
    output logic                    frame_done
);

    localparam int unsigned NCELL = MAX_ORDER + 1;

    // config registers
    logic signed [15:0] warp_a_reg;
    logic [15:0]        warp_b_reg;
    logic [5:0]         order_reg;
    logic               cfg_write;
    logic [5:0]         order_eff;
    logic [7:0]         max_ord8;

    // control
    cfw_pkg::state_t    state_reg;
    cfw_pkg::state_t    state_next;
    logic               accept;
    logic               drain_load;
    logic               last_out;
    logic               busy;
    logic [5:0]         drain_idx_reg;
    logic [5:0]         drain_idx_next;
    cfw_pkg::ctl_t      ctl;

    // output register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [23:0] out_value_reg;
    logic [5:0]         out_index_reg;
    logic               out_done_reg;

    // chain
    cfw_pkg::tok_t      in_tok;
    cfw_pkg::tok_t      tok [NCELL];
    logic signed [31:0] g_vals [NCELL];
    logic [NCELL-1:0]   busy_vec;
    logic [NCELL-1:0]   active;

    // ---------------- register port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warp_a_reg <= cfw_pkg::WARP_A_RST;
            warp_b_reg <= cfw_pkg::WARP_B_RST;
            order_reg  <= cfw_pkg::OUTPUT_ORDER_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                cfw_pkg::REG_WARP_A:       warp_a_reg <= pwdata[15:0];
                cfw_pkg::REG_WARP_B:       warp_b_reg <= pwdata[15:0];
                cfw_pkg::REG_OUTPUT_ORDER: order_reg  <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            cfw_pkg::REG_WARP_A:       prdata = {{16{warp_a_reg[15]}}, warp_a_reg};
            cfw_pkg::REG_WARP_B:       prdata = {16'd0, warp_b_reg};
            cfw_pkg::REG_OUTPUT_ORDER: prdata = {26'd0, order_reg};
            default:                   prdata = '0;
        endcase
    end

    // order above the last cell's index acts as the last cell
    assign max_ord8  = 8'(MAX_ORDER);
    assign order_eff = ({2'b00, order_reg} > max_ord8) ? max_ord8[5:0] : order_reg;

    // ---------------- cell chain ----------------
    // head cell sees the coefficient as its left old value and zero as left new value
    assign accept         = in_valid && in_ready;
    assign in_tok.valid   = accept;
    assign in_tok.old_val = {{8{coefficient[23]}}, coefficient};
    assign in_tok.new_val = '0;

    genvar j;
    generate
        for (j = 0; j < NCELL; j++) begin : g_chain
            cfw_pkg::tok_t      left_tok;
            logic signed [31:0] right_val;

            assign active[j]   = (8'(j) <= {2'b00, order_eff});
            assign busy_vec[j] = tok[j].valid;

            if (j == 0) begin : g_first
                assign left_tok = in_tok;
            end
            else begin : g_mid
                assign left_tok = tok[j-1];
            end

            if (j == NCELL - 1) begin : g_tail
                assign right_val = '0;
            end
            else begin : g_body
                assign right_val = g_vals[j+1];
            end

            cfw_cell #(
                .IDX (j)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .active   (active[j]),
                .warp_a   (warp_a_reg),
                .warp_b   (warp_b_reg),
                .ctl      (ctl),
                .in_tok   (left_tok),
                .shift_in (right_val),
                .out_tok  (tok[j]),
                .g_value  (g_vals[j])
            );
        end
    endgenerate

    // wavefront still moving somewhere in the chain
    assign busy = |busy_vec;

    // ---------------- frame control ----------------
    assign last_out = (drain_idx_reg == order_eff);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cfw_pkg::ST_RUN:
            begin
                if (accept && frame_last)
                begin
                    state_next = cfw_pkg::ST_FLUSH;
                end
            end
            cfw_pkg::ST_FLUSH:
            begin
                if (!busy)
                begin
                    state_next = cfw_pkg::ST_DRAIN;
                end
            end
            cfw_pkg::ST_DRAIN:
            begin
                if (drain_load && last_out)
                begin
                    state_next = cfw_pkg::ST_RUN;
                end
            end
            default: state_next = cfw_pkg::ST_RUN;
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        drain_load = 1'b0;
        unique case (state_reg)
            cfw_pkg::ST_RUN:   in_ready   = 1'b1;
            cfw_pkg::ST_FLUSH: in_ready   = 1'b0;
            cfw_pkg::ST_DRAIN: drain_load = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    // drain shifts the chain toward cell 0; the final step wipes every cell
    assign ctl.shift = drain_load;
    assign ctl.clear = drain_load && last_out;

    always_comb
    begin
        drain_idx_next = drain_idx_reg;
        if (drain_load)
        begin
            drain_idx_next = last_out ? 6'd0 : drain_idx_reg + 6'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (drain_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfw_pkg::ST_RUN;
            drain_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            drain_idx_reg <= drain_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (drain_load)
        begin
            out_value_reg <= cfw_pkg::sat24(g_vals[0]);
            out_index_reg <= drain_idx_reg;
            out_done_reg  <= last_out;
        end
    end

    assign out_valid    = out_valid_reg;
    assign warped_value = out_value_reg;
    assign warped_index = out_index_reg;
    assign frame_done   = out_done_reg;

endmodule

`default_nettype wire

// File: src/cfw_cell.sv
// cfw_cell: one warped coefficient of the chain with its update arithmetic
// depends on cfw_pkg
`timescale 1ns / 1ps
`default_nettype none

module cfw_cell #(
    parameter int unsigned IDX = 0
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               active,
    input  wire logic signed [15:0] warp_a,
    input  wire logic [15:0]        warp_b,
    input  wire cfw_pkg::ctl_t      ctl,
    input  wire cfw_pkg::tok_t      in_tok,
    input  wire logic signed [31:0] shift_in,
    output cfw_pkg::tok_t           out_tok,
    output logic signed [31:0]      g_value
);

    logic signed [31:0] g_reg;
    logic signed [31:0] g_next;
    cfw_pkg::tok_t      tok_reg;
    cfw_pkg::tok_t      tok_next;
    logic signed [48:0] prod_a;
    logic signed [34:0] sum;
    logic signed [31:0] upd;

    generate
        if (IDX == 1) begin : g_bcell
            // g1 = b*g0old + a*g1old
            logic signed [16:0] b_s;
            logic signed [48:0] prod_b;
            assign b_s    = {1'b0, warp_b};
            assign prod_b = b_s * in_tok.old_val;
            assign prod_a = warp_a * g_reg;
            assign sum    = 35'(cfw_pkg::rnd15(prod_b)) + 35'(cfw_pkg::rnd15(prod_a));
        end
        else begin : g_acell
            // gj = g(j-1)old + a*(gjold - g(j-1)new); head cell sees c and zero
            logic signed [32:0] diff;
            assign diff   = 33'(g_reg) - 33'(in_tok.new_val);
            assign prod_a = warp_a * diff;
            assign sum    = 35'(in_tok.old_val) + 35'(cfw_pkg::rnd15(prod_a));
        end
    endgenerate

    assign upd = cfw_pkg::sat32(sum);

    always_comb
    begin
        g_next           = g_reg;
        tok_next.valid   = 1'b0;
        tok_next.old_val = g_reg;
        tok_next.new_val = upd;
        if (ctl.clear)
        begin
            g_next = '0;
        end
        else if (ctl.shift)
        begin
            g_next = shift_in;
        end
        else if (in_tok.valid && active)
        begin
            g_next         = upd;
            tok_next.valid = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_reg   <= '0;
            tok_reg <= '0;
        end
        else
        begin
            g_reg   <= g_next;
            tok_reg <= tok_next;
        end
    end

    assign out_tok = tok_reg;
    assign g_value = g_reg;

endmodule

`default_nettype wire

// File: src/cfw_checker.sv
// cfw_checker: port-level assertions for the cepstrum frequency warp block
// bound to cepstrum_frequency_warp; no package dependency
`timescale 1ns / 1ps
`default_nettype none

module cfw_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               pready,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               frame_last,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [23:0] warped_value,
    input wire logic               frame_done
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(warped_value))
        else $error("stalled result changed");

    // frame end closes the input
    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && frame_last |=> !in_ready)
        else $error("input open right after frame end");

    // input never runs while a frame is only partly drained
    a_no_mix: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid || frame_done)
        else $error("input open during drain");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind cepstrum_frequency_warp cfw_checker u_cfw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .frame_last   (frame_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .warped_value (warped_value),
    .frame_done   (frame_done)
);

`default_nettype wire

// File: verif/cfw_warp_checker.sv
// cfw_warp_checker: watches the register, coefficient and warped-item channels,
// predicts every warped item and compares; depends on cfw_pkg
`timescale 1ns / 1ps

module cfw_warp_checker #(
    parameter int unsigned MAX_ORDER = cfw_pkg::MAX_ORDER_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [23:0] coefficient,
    input  logic               frame_last,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [23:0] warped_value,
    input  logic [5:0]         warped_index,
    input  logic               frame_done,
    output int                 mismatches,
    output int                 pending_results
);

    localparam longint STATE_HI = 64'sd2147483647;
    localparam longint STATE_LO = -64'sd2147483648;
    localparam longint OUT_HI   = 64'sd8388607;
    localparam longint OUT_LO   = -64'sd8388608;
    localparam int     REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [23:0] value;
        logic [5:0]         index;
        logic               done;
    } warped_item_t;

    // shadow of the warped-coefficient array, Q15.16
    longint       shadow_coefs [0:MAX_ORDER];
    longint       warp_a_q15;
    longint       warp_b_q15;
    logic [5:0]   order_reg;
    warped_item_t expected_warped [$];

    // Q.31 product back to Q.16, half rounds up
    function automatic longint round_q15(input longint p);
        return (p + 64'sd16384) >>> 15;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void clear_shadow();
        int k;
        for (k = 0; k <= MAX_ORDER; k++)
        begin
            shadow_coefs[k] = 0;
        end
    endfunction

    function automatic void apply_coefficient(input logic signed [23:0] c, input logic last);
        int unsigned  top;
        int unsigned  j;
        longint       prev_old;
        longint       prev_new;
        longint       cur_old;
        longint       v;
        warped_item_t item;
        top = (order_reg > MAX_ORDER) ? MAX_ORDER : order_reg;
        prev_old = shadow_coefs[0];
        prev_new = clip(longint'(c) + round_q15(warp_a_q15 * prev_old), STATE_LO, STATE_HI);
        shadow_coefs[0] = prev_new;
        for (j = 1; j <= top; j++)
        begin
            cur_old = shadow_coefs[j];
            if (j == 1)
            begin
                shadow_coefs[j] = clip(round_q15(warp_b_q15 * prev_old)
                                       + round_q15(warp_a_q15 * cur_old), STATE_LO, STATE_HI);
            end
            else
            begin
                shadow_coefs[j] = clip(prev_old + round_q15(warp_a_q15 * (cur_old - prev_new)),
                                       STATE_LO, STATE_HI);
            end
            prev_old = cur_old;
            prev_new = shadow_coefs[j];
        end
        if (last)
        begin
            for (j = 0; j <= top; j++)
            begin
                v = clip(shadow_coefs[j], OUT_LO, OUT_HI);
                item.value = v[23:0];
                item.index = j[5:0];
                item.done  = (j == top);
                expected_warped.push_back(item);
            end
            clear_shadow();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        warped_item_t want;
        if (!rst_n)
        begin
            clear_shadow();
            warp_a_q15 = longint'(cfw_pkg::WARP_A_RST);
            warp_b_q15 = longint'(cfw_pkg::WARP_B_RST);
            order_reg  = cfw_pkg::OUTPUT_ORDER_RST;
            expected_warped.delete();
            mismatches      = 0;
            pending_results = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    cfw_pkg::REG_WARP_A:       warp_a_q15 = longint'($signed(pwdata[15:0]));
                    cfw_pkg::REG_WARP_B:       warp_b_q15 = longint'(pwdata[15:0]);
                    cfw_pkg::REG_OUTPUT_ORDER: order_reg  = pwdata[5:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                apply_coefficient(coefficient, frame_last);
            end
            if (out_valid && out_ready)
            begin
                if (expected_warped.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                    begin
                        $display("%0t: unexpected warped item value %0d index %0d done %0b",
                                 $realtime, warped_value, warped_index, frame_done);
                    end
                    mismatches++;
                end
                else
                begin
                    want = expected_warped.pop_front();
                    if (warped_value !== want.value || warped_index !== want.index
                        || frame_done !== want.done)
                    begin
                        if (mismatches < REPORT_LIMIT)
                        begin
                            $display({"%0t: warped item mismatch, expected value %0d index %0d ",
                                      "done %0b, got value %0d index %0d done %0b"},
                                     $realtime, want.value, want.index, want.done,
                                     warped_value, warped_index, frame_done);
                        end
                        mismatches++;
                    end
                end
            end
            pending_results = expected_warped.size();
        end
    end

endmodule

// File: verif/tb_cepstrum_frequency_warp.sv
// tb_cepstrum_frequency_warp: stimulus and verdict for the cepstrum frequency warp
// block; depends on cfw_pkg, cepstrum_frequency_warp and cfw_warp_checker
`timescale 1ns / 1ps

module tb_cepstrum_frequency_warp;

    localparam int ITEMS_PER_PHASE = 48;
    localparam int SETTLE_CYCLES   = 100;   // wavefront across 64 cells plus margin

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic signed [23:0] coefficient;
    logic               frame_last;
    logic               out_valid;
    logic               out_ready;
    logic signed [23:0] warped_value;
    logic [5:0]         warped_index;
    logic               frame_done;

    int mismatches;
    int pending_results;
    int send_idle_pct;      // chance in a hundred that the sender idles a cycle
    int recv_idle_pct;      // chance in a hundred that the receiver stalls a cycle

    cepstrum_frequency_warp dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .coefficient  (coefficient),
        .frame_last   (frame_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .warped_value (warped_value),
        .warped_index (warped_index),
        .frame_done   (frame_done)
    );

    // the checker sees every channel and keeps its own model of the warp array
    cfw_warp_checker u_warp_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .coefficient     (coefficient),
        .frame_last      (frame_last),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .warped_value    (warped_value),
        .warped_index    (warped_index),
        .frame_done      (frame_done),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // receiver side: stall at random, decided on the falling edge
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // b = 1 - a*a in Q1.15, as software would program it
    function automatic int matched_b(input int a);
        return 32768 - ((a * a + 16384) >>> 15);
    endfunction

    // two-phase register write; lands on the edge closing the access cycle
    task automatic write_reg(input logic [1:0] reg_index, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_warp(input int a, input int b, input int order);
        write_reg(cfw_pkg::REG_WARP_A, 32'(a));
        write_reg(cfw_pkg::REG_WARP_B, 32'(b));
        write_reg(cfw_pkg::REG_OUTPUT_ORDER, 32'(order));
    endtask

    // one coefficient item; valid stays up with the payload until accepted
    task automatic send_coef(input logic signed [23:0] c, input logic last);
        @(negedge clk);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        coefficient <= c;
        frame_last  <= last;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    // drop valid, let every expected item drain, then let the chain settle
    // (a partial frame leaves the wavefront running with nothing expected)
    task automatic wait_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic signed [23:0] random_coef();
        int pick;
        pick = $urandom_range(7, 0);
        if (pick == 0)
        begin
            return 24'sh7F_FFFF;
        end
        else if (pick == 1)
        begin
            return 24'sh80_0000;
        end
        return 24'($urandom);
    endfunction

    // random warp settings, mostly small orders and matched b
    task automatic random_config();
        int a;
        int b;
        int order;
        case ($urandom_range(5, 0))
            0:       a = 32767;
            1:       a = -32767;
            default: a = int'($urandom_range(65534, 0)) - 32767;
        endcase
        b = ($urandom_range(7, 0) == 0) ? int'($urandom_range(65535, 0)) : matched_b(a);
        order = ($urandom_range(5, 0) == 0) ? 63 : int'($urandom_range(8, 0));
        set_warp(a, b, order);
    endtask

    // a run of whole frames under a few random settings
    task automatic random_phase(input int send_pct, input int recv_pct);
        int sent;
        int frames;
        int len;
        int k;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < ITEMS_PER_PHASE)
        begin
            random_config();
            frames = $urandom_range(3, 1);
            repeat (frames)
            begin
                len = $urandom_range(6, 1);
                for (k = 1; k <= len; k++)
                begin
                    send_coef(random_coef(), k == len);
                end
                sent += len;
            end
            wait_quiet();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        coefficient   = '0;
        frame_last    = 1'b0;
        out_ready     = 1'b0;
        send_idle_pct = 18;
        recv_idle_pct = 52;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: a zero, b one, order 24, one-item frame at full scale
        send_coef(24'sh7F_FFFF, 1'b1);
        wait_quiet();

        // strongest positive warp, b zero, widest order; sums saturate the output
        set_warp(32767, 0, 63);
        send_coef(24'sh7F_FFFF, 1'b0);
        send_coef(24'sh7F_FFFF, 1'b0);
        send_coef(24'sh55_5555, 1'b0);
        send_coef(24'shAA_AAAA, 1'b1);
        wait_quiet();

        // strongest negative warp, order zero: only g0 comes out
        set_warp(-32767, matched_b(-32767), 0);
        send_coef(24'sh80_0000, 1'b0);
        send_coef(24'sh7F_FFFF, 1'b1);
        wait_quiet();

        // b above one, used as its raw 16-bit value
        set_warp(16384, 65535, 1);
        send_coef(24'sh12_3456, 1'b0);
        send_coef(24'sh80_0000, 1'b1);
        wait_quiet();

        // order changed mid-frame: cells above the new order hold until the clear
        set_warp(-12345, matched_b(-12345), 5);
        send_coef(24'sh40_0000, 1'b0);
        send_coef(24'shC0_0000, 1'b0);
        send_coef(24'sh0F_F0F0, 1'b0);
        wait_quiet();
        write_reg(cfw_pkg::REG_OUTPUT_ORDER, 32'd2);
        send_coef(24'sh7F_FFFF, 1'b0);
        send_coef(24'shF0_0F0F, 1'b0);
        wait_quiet();
        write_reg(cfw_pkg::REG_OUTPUT_ORDER, 32'd7);
        send_coef(24'sh00_0000, 1'b1);
        wait_quiet();

        // random frames under three idling patterns
        random_phase(18, 52);
        random_phase(52, 18);
        random_phase(0, 0);

        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
src/cfw_pkg.sv
src/cfw_cell.sv
src/cepstrum_frequency_warp.sv
src/cfw_checker.sv
verif/cfw_warp_checker.sv
verif/tb_cepstrum_frequency_warp.sv
